// ===== rtl/bsnf_pkg.sv =====
// Shared constants, types and helpers for the 3x3 speckle noise filter.
// Used by bsnf_lines and binary_speck_noise_filter_3x3; depends on nothing.
`default_nettype none

package bsnf_pkg;

  // Largest frame the line memories are sized for
  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned MAX_HEIGHT = 1024;
  localparam int unsigned MIN_DIM    = 3;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned THR_W      = 4;
  localparam int unsigned CNT_W      = 4;   // zero count of a 3x3 window, 0..9
  localparam int unsigned WIN_TAPS   = 9;

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);
  localparam int unsigned WID_W = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HGT_W = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned LAG_W = $clog2(MAX_WIDTH + 2);

  typedef logic [COL_W-1:0] col_t;
  typedef logic [PIX_W-1:0] pix_t;

  localparam pix_t            PIX_WHITE   = '1;
  localparam logic [CNT_W-1:0] DENSE_ZEROS = CNT_W'(7);

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_THRESH = 2'd2
  } cfg_idx_e;

  function automatic int unsigned clamp_dim(logic [CFG_DATA_W-1:0] v, int unsigned hi);
    int unsigned x;
    x = int'(v);
    if (x < MIN_DIM) return MIN_DIM;
    if (x > hi) return hi;
    return x;
  endfunction

  localparam logic [WID_W-1:0] RST_WIDTH  = WID_W'(clamp_dim(CFG_DATA_W'(856), MAX_WIDTH));
  localparam logic [HGT_W-1:0] RST_HEIGHT = HGT_W'(clamp_dim(CFG_DATA_W'(540), MAX_HEIGHT));
  localparam logic [THR_W-1:0] RST_THRESH = THR_W'(3);

  // Line buffer command for one cycle
  typedef struct packed {
    logic fill;      // row 0 pixel goes straight into the centre line
    logic first;     // that pixel is column 0 of the frame
    logic prime;     // preload the right-hand tap before the first window
    logic step;      // one output pixel is produced this cycle
    col_t fill_col;
    col_t cur_col;   // column of the output pixel
    col_t left_col;  // column left of it, wrapping to the row end
    col_t next_col;  // column read ahead for the next window
    pix_t fill_pix;
    pix_t newest;    // newest input, becomes the centre line entry
    pix_t left;      // filtered left neighbour, becomes the above line entry
  } lb_cmd_t;

  // Window taps that come from the line memories
  typedef struct packed {
    pix_t above_l;
    pix_t above_c;
    pix_t above_r;
    pix_t centre;
    pix_t right;
  } lb_win_t;

endpackage

`default_nettype wire

// ===== rtl/bsnf_lines.sv =====
// Line memories of the speckle filter: filtered row above and raw centre row,
// with the read-ahead window taps. Depends on bsnf_pkg.
`default_nettype none

module bsnf_lines import bsnf_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire lb_cmd_t cmd_i,
  output lb_win_t      win_o
);

  pix_t ctr_mem [MAX_WIDTH];
  pix_t abv_mem [MAX_WIDTH];

  pix_t ctr_rd_q;
  pix_t abv_rd_q;
  logic byp_q;
  pix_t byp_pix_q;
  pix_t cen_q;
  pix_t abv_c_q;
  pix_t abv_l_q;

  logic ctr_we;
  col_t ctr_wa;
  pix_t ctr_wd;
  logic rd_en;
  pix_t abv_r;

  assign ctr_we = cmd_i.fill | cmd_i.step;
  assign ctr_wa = cmd_i.fill ? cmd_i.fill_col : cmd_i.cur_col;
  assign ctr_wd = cmd_i.fill ? cmd_i.fill_pix : cmd_i.newest;
  assign rd_en  = cmd_i.step | cmd_i.prime;

  // same-cycle write of the address read ahead (narrow frames only)
  assign abv_r = byp_q ? byp_pix_q : abv_rd_q;

  always_ff @(posedge clk_i) begin
    if (ctr_we) begin
      ctr_mem[ctr_wa] <= ctr_wd;
    end
    if (rd_en) begin
      ctr_rd_q <= ctr_mem[cmd_i.next_col];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      abv_mem[cmd_i.left_col] <= cmd_i.left;
    end
    if (rd_en) begin
      abv_rd_q <= abv_mem[cmd_i.next_col];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else if (rd_en) begin
      byp_q <= cmd_i.step && (cmd_i.left_col == cmd_i.next_col);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      byp_pix_q <= cmd_i.left;
    end
    if (cmd_i.step) begin
      abv_l_q <= abv_c_q;
      abv_c_q <= abv_r;
      cen_q   <= ctr_rd_q;
    end else if (cmd_i.fill && cmd_i.first) begin
      cen_q   <= cmd_i.fill_pix;
    end
  end

  assign win_o.above_l = abv_l_q;
  assign win_o.above_c = abv_c_q;
  assign win_o.above_r = abv_r;
  assign win_o.centre  = cen_q;
  assign win_o.right   = ctr_rd_q;

endmodule

`default_nettype wire

// ===== rtl/binary_speck_noise_filter_3x3.sv =====
// Top level of the 3x3 speckle noise filter: position counters, window
// decision and output register. Depends on bsnf_pkg and bsnf_lines.
`default_nettype none

// Streaming speckle remover for 8-bit pixels in raster order. Every accepted
// input item yields exactly one result item; out_valid_o marks whether that
// item carries a finished pixel. The result for pixel k leaves with input
// item k + width + 1, so after the last pixel of a frame width + 1 drain
// items (cmd 1) push the tail out; out_last_o flags the final pixel, after
// which the next pixel starts a new frame. Interior pixels look at a 3x3
// window whose row above and left neighbour are already filtered: a zero
// pixel with at most noise_threshold zeros in the window becomes 255, a
// nonzero pixel with 7 or more zeros becomes 0; border pixels pass as they
// are. Throughput is one item per clock with no gaps while res_stall_i does not
// hold the output register: the two line memories (MAX_WIDTH x 8 each, one write
// and one registered read per cycle) are read one column ahead of the window, so
// the decision for the current item needs only registered taps. Results appear
// in an output register in the cycle after acceptance; in_stall_o rises only
// while that register is full and res_stall_i holds it. There is no clearing
// pass after reset. Width and height are clamped to 3..MAX_WIDTH/MAX_HEIGHT;
// any register write restarts the frame and must happen while idle.
module binary_speck_noise_filter_3x3 import bsnf_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // input items
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic                  cmd_i,
  input  wire logic [PIX_W-1:0]      pixel_in_i,
  // result items
  output logic                       res_valid_o,
  input  wire logic                  res_stall_i,
  output logic                       out_valid_o,
  output logic [PIX_W-1:0]           out_pixel_o,
  output logic                       out_last_o,
  // register writes
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  // Configuration, stored already clamped
  logic [WID_W-1:0] width_q,  width_d;
  logic [HGT_W-1:0] height_q, height_d;
  logic [THR_W-1:0] thresh_q, thresh_d;

  // Frame position
  col_t             in_col_q,  in_col_d;
  logic [HGT_W-1:0] in_row_q,  in_row_d;
  col_t             out_col_q, out_col_d;
  logic [HGT_W-1:0] out_row_q, out_row_d;
  logic [LAG_W-1:0] lag_q,     lag_d;     // pixels taken but not yet emitted

  // Pixel history
  pix_t newest_q, newest_d;
  pix_t older_q,  older_d;
  pix_t left_q,   left_d;                // filtered left neighbour

  // Output register
  logic res_vld_q;
  logic out_vld_q;
  pix_t out_pix_q;
  logic out_last_q;

  logic advance;
  logic take;
  logic cfg_we;
  logic restart;
  logic in_done;
  logic pix_ok;
  logic acc;
  logic step;
  logic last;
  logic lag_full;
  logic in_col_end;
  logic out_col_end;
  logic interior;
  pix_t cur;
  pix_t result;
  logic [CNT_W-1:0] zeros;
  pix_t nb [WIN_TAPS];
  logic [WID_W:0] nxt_sum;
  logic [WID_W:0] nxt_wrap;
  col_t next_col;
  col_t left_col;

  lb_cmd_t lb_cmd;
  lb_win_t win;

  // Handshake: a new item enters whenever the output register can move
  assign advance     = !res_vld_q || !res_stall_i;
  assign in_stall_o  = !advance;
  assign take        = in_valid_i && advance;
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  // Item classification
  assign in_done  = in_row_q >= height_q;
  assign pix_ok   = (cmd_i == CMD_PIXEL) && !in_done;
  assign lag_full = lag_q >= (LAG_W'(width_q) + LAG_W'(1));
  assign acc      = take && pix_ok;
  // a pixel item emits once the lag is a full line plus one; a drain or a
  // surplus pixel emits only after the whole frame is in
  assign step     = take && (pix_ok ? lag_full : (in_done && (lag_q != '0)));
  assign last     = step && !pix_ok && (lag_q == LAG_W'(1));
  assign cur      = pix_ok ? pixel_in_i : '0;

  assign in_col_end  = WID_W'(in_col_q)  == (width_q - WID_W'(1));
  assign out_col_end = WID_W'(out_col_q) == (width_q - WID_W'(1));

  // Read-ahead column: two right of the output column, wrapping into the next row, or column 1 before output starts
  assign nxt_sum  = (WID_W + 1)'(out_col_q) + (WID_W + 1)'(2);
  assign nxt_wrap = (nxt_sum >= (WID_W + 1)'(width_q)) ? nxt_sum - (WID_W + 1)'(width_q)
                                                       : nxt_sum;
  assign next_col = acc && !step ? col_t'(1) : COL_W'(nxt_wrap);
  assign left_col = (out_col_q == '0) ? COL_W'(width_q - WID_W'(1)) : out_col_q - col_t'(1);

  always_comb begin
    lb_cmd          = '0;
    lb_cmd.step     = step;
    lb_cmd.fill     = acc && !step && (in_row_q == '0);
    lb_cmd.first    = in_col_q == '0;
    lb_cmd.prime    = acc && !step && (in_row_q == HGT_W'(1)) && (in_col_q == '0);
    lb_cmd.fill_col = in_col_q;
    lb_cmd.cur_col  = out_col_q;
    lb_cmd.left_col = left_col;
    lb_cmd.next_col = next_col;
    lb_cmd.fill_pix = pixel_in_i;
    lb_cmd.newest   = newest_q;
    lb_cmd.left     = left_q;
  end

  bsnf_lines u_lines (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (lb_cmd),
    .win_o  (win)
  );

  // 3x3 window: filtered row above and left, raw centre/right and row below
  assign nb[0] = win.above_l;
  assign nb[1] = win.above_c;
  assign nb[2] = win.above_r;
  assign nb[3] = left_q;
  assign nb[4] = win.centre;
  assign nb[5] = win.right;
  assign nb[6] = older_q;
  assign nb[7] = newest_q;
  assign nb[8] = cur;

  always_comb begin
    zeros = '0;
    for (int i = 0; i < WIN_TAPS; i++) begin
      zeros = zeros + CNT_W'(nb[i] == '0);
    end
  end

  assign interior = (out_row_q != '0) && ((out_row_q + HGT_W'(1)) < height_q) &&
                    (out_col_q != '0) && ((WID_W'(out_col_q) + WID_W'(1)) < width_q);

  always_comb begin
    result = win.centre;
    if (interior) begin
      if (win.centre == '0) begin
        if (zeros <= CNT_W'(thresh_q)) result = PIX_WHITE;
      end else if (zeros >= DENSE_ZEROS) begin
        result = '0;
      end
    end
  end

  // Next state of configuration and counters
  always_comb begin
    width_d   = width_q;
    height_d  = height_q;
    thresh_d  = thresh_q;
    restart   = 1'b0;
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    lag_d     = lag_q;
    newest_d  = newest_q;
    older_d   = older_q;
    left_d    = left_q;

    if (cfg_we) begin
      unique case (cfg_index_i)
        CFG_WIDTH: begin
          width_d = WID_W'(clamp_dim(cfg_data_i, MAX_WIDTH));
          restart = 1'b1;
        end
        CFG_HEIGHT: begin
          height_d = HGT_W'(clamp_dim(cfg_data_i, MAX_HEIGHT));
          restart  = 1'b1;
        end
        CFG_THRESH: begin
          thresh_d = cfg_data_i[THR_W-1:0];
          restart  = 1'b1;
        end
        default: ;
      endcase
    end

    if (acc) begin
      if (in_col_end) begin
        in_col_d = '0;
        in_row_d = in_row_q + HGT_W'(1);
      end else begin
        in_col_d = in_col_q + col_t'(1);
      end
    end

    if (acc && !step) begin
      lag_d = lag_q + LAG_W'(1);
    end else if (step && !acc) begin
      lag_d = lag_q - LAG_W'(1);
    end

    if (acc || step) begin
      older_d  = newest_q;
      newest_d = cur;
    end

    if (step) begin
      left_d = result;
      if (out_col_end) begin
        out_col_d = '0;
        out_row_d = out_row_q + HGT_W'(1);
      end else begin
        out_col_d = out_col_q + col_t'(1);
      end
    end

    // frame end or register write: back to the top-left corner
    if (last || restart) begin
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
      lag_d     = '0;
      left_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= RST_WIDTH;
      height_q  <= RST_HEIGHT;
      thresh_q  <= RST_THRESH;
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      lag_q     <= '0;
      newest_q  <= '0;
      older_q   <= '0;
      left_q    <= '0;
      res_vld_q <= 1'b0;
    end else begin
      width_q   <= width_d;
      height_q  <= height_d;
      thresh_q  <= thresh_d;
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      lag_q     <= lag_d;
      newest_q  <= newest_d;
      older_q   <= older_d;
      left_q    <= left_d;
      if (advance) begin
        res_vld_q <= take;
      end
    end
  end

  // Result payload, loaded with every item that enters
  always_ff @(posedge clk_i) begin
    if (take) begin
      out_vld_q  <= step;
      out_pix_q  <= step ? result : '0;
      out_last_q <= last;
    end
  end

  assign res_valid_o = res_vld_q;
  assign out_valid_o = out_vld_q;
  assign out_pixel_o = out_pix_q;
  assign out_last_o  = out_last_q;

endmodule

`default_nettype wire
